// ===== src/fscws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-string window search package
// Shared item types, codes, microcode word format and the microcode program.
// ----------------------------------------------------------------------------
package fscws_pkg;

	// Field widths fixed by the item format.
	localparam int KIND_W = 2;
	localparam int STR_W  = 2;
	localparam int CHAR_W = 8;
	localparam int WIN_W  = 8;
	localparam int POS_W  = 7;

	// Input item kinds.
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [STR_W-1:0]  which_string;
		logic [CHAR_W-1:0] char_value;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos_first;
		logic [POS_W-1:0] pos_second;
		logic [POS_W-1:0] pos_third;
		logic [POS_W-1:0] pos_fourth;
	} out_item_t;

	// Microprogram step addresses.
	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_INIT,
		STEP_SINIT,
		STEP_READ,
		STEP_CMP,
		STEP_CHKI,
		STEP_WDONE,
		STEP_NEXTQ,
		STEP_NEXTJ,
		STEP_HIT,
		STEP_MISS
	} step_t;

	// Branch conditions tested by a microcode word.
	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_SEARCH,
		COND_NO_WINDOW,
		COND_SHORT,
		COND_MISMATCH,
		COND_I_LAST,
		COND_S_LAST,
		COND_Q_ZERO,
		COND_J_ZERO,
		COND_OUT_BUSY
	} cond_t;

	// Datapath actions of one step.
	typedef struct packed {
		logic accept;
		logic ld_j;
		logic dec_j;
		logic ld_s1;
		logic inc_s;
		logic ld_q;
		logic dec_q;
		logic clr_i;
		logic inc_i;
		logic st_pos;
		logic emit_hit;
		logic emit_miss;
	} ctrl_t;

	// Condition flags reported by the datapath.
	typedef struct packed {
		logic search_acc;
		logic no_window;
		logic short_str;
		logic mismatch;
		logic i_last;
		logic s_last;
		logic q_zero;
		logic j_zero;
		logic out_busy;
	} status_t;

	typedef struct packed {
		cond_t cond;
		step_t on_true;
		step_t on_false;
		ctrl_t act;
	} uword_t;

	// The search program. Actions of a step happen unconditionally; the
	// condition only selects the next step.
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		w = '0;
		unique case (step)
			STEP_IDLE: begin
				w.cond = COND_SEARCH; w.on_true = STEP_INIT; w.on_false = STEP_IDLE;
				w.act.accept = 1'b1;
			end
			STEP_INIT: begin
				w.cond = COND_NO_WINDOW; w.on_true = STEP_MISS; w.on_false = STEP_SINIT;
				w.act.ld_j = 1'b1; w.act.ld_s1 = 1'b1;
			end
			STEP_SINIT: begin
				w.cond = COND_SHORT; w.on_true = STEP_NEXTJ; w.on_false = STEP_READ;
				w.act.ld_q = 1'b1; w.act.clr_i = 1'b1;
			end
			STEP_READ: begin
				w.cond = COND_ALWAYS; w.on_true = STEP_CMP; w.on_false = STEP_CMP;
			end
			STEP_CMP: begin
				w.cond = COND_MISMATCH; w.on_true = STEP_NEXTQ; w.on_false = STEP_CHKI;
			end
			STEP_CHKI: begin
				w.cond = COND_I_LAST; w.on_true = STEP_WDONE; w.on_false = STEP_READ;
				w.act.inc_i = 1'b1;
			end
			STEP_WDONE: begin
				w.cond = COND_S_LAST; w.on_true = STEP_HIT; w.on_false = STEP_SINIT;
				w.act.st_pos = 1'b1; w.act.inc_s = 1'b1;
			end
			STEP_NEXTQ: begin
				w.cond = COND_Q_ZERO; w.on_true = STEP_NEXTJ; w.on_false = STEP_READ;
				w.act.dec_q = 1'b1; w.act.clr_i = 1'b1;
			end
			STEP_NEXTJ: begin
				w.cond = COND_J_ZERO; w.on_true = STEP_MISS; w.on_false = STEP_SINIT;
				w.act.dec_j = 1'b1; w.act.ld_s1 = 1'b1;
			end
			STEP_HIT: begin
				w.cond = COND_OUT_BUSY; w.on_true = STEP_HIT; w.on_false = STEP_IDLE;
				w.act.emit_hit = 1'b1;
			end
			STEP_MISS: begin
				w.cond = COND_OUT_BUSY; w.on_true = STEP_MISS; w.on_false = STEP_IDLE;
				w.act.emit_miss = 1'b1;
			end
			default: begin
				w.cond = COND_ALWAYS; w.on_true = STEP_IDLE; w.on_false = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/fscws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module fscws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== src/fscws_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the program table with conditional two-way jumps.
// ----------------------------------------------------------------------------
module fscws_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  fscws_pkg::status_t status,
	output fscws_pkg::ctrl_t   ctrl
);

	fscws_pkg::step_t  step_q;
	fscws_pkg::step_t  step_next;
	fscws_pkg::uword_t word;
	logic              taken;

	// Fetch the current control word.
	always_comb begin
		word = fscws_pkg::ucode_rom(step_q);
	end

	// Select the branch condition.
	always_comb begin
		unique case (word.cond)
			fscws_pkg::COND_ALWAYS:    taken = 1'b1;
			fscws_pkg::COND_SEARCH:    taken = status.search_acc;
			fscws_pkg::COND_NO_WINDOW: taken = status.no_window;
			fscws_pkg::COND_SHORT:     taken = status.short_str;
			fscws_pkg::COND_MISMATCH:  taken = status.mismatch;
			fscws_pkg::COND_I_LAST:    taken = status.i_last;
			fscws_pkg::COND_S_LAST:    taken = status.s_last;
			fscws_pkg::COND_Q_ZERO:    taken = status.q_zero;
			fscws_pkg::COND_J_ZERO:    taken = status.j_zero;
			fscws_pkg::COND_OUT_BUSY:  taken = status.out_busy;
			default:                   taken = 1'b1;
		endcase
	end

	// Next step address.
	always_comb begin
		step_next = taken ? word.on_true : word.on_false;
	end

	// Datapath actions come straight from the table.
	always_comb begin
		ctrl = word.act;
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fscws_pkg::STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// ===== src/fscws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search datapath
// String memory, length counters, scan registers, byte compare and result
// register, all driven by the microcode control word.
// ----------------------------------------------------------------------------
module fscws_datapath #(
	parameter int MAX_LEN = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fscws_pkg::ctrl_t                     ctrl,
	output fscws_pkg::status_t                   status,
	input  logic                                 item_valid,
	input  fscws_pkg::in_item_t                  item,
	input  logic                                 result_ready,
	output logic                                 result_valid,
	output fscws_pkg::out_item_t                 result,
	input  logic                                 cfg_write_en,
	input  logic [fscws_pkg::WIN_W-1:0]          cfg_write_data
);

	localparam int IW     = $clog2(MAX_LEN);
	localparam int LW     = $clog2(MAX_LEN + 1);
	localparam int WW     = fscws_pkg::WIN_W;
	localparam int CW     = (LW > WW) ? LW : WW;
	localparam int SW     = fscws_pkg::STR_W;
	localparam int AW     = SW + IW;
	localparam int DEPTH  = (2 ** SW) * (2 ** IW);
	localparam int PW     = fscws_pkg::POS_W;
	localparam logic [LW-1:0] FULL_LEN = LW'(MAX_LEN);

	logic [WW-1:0]  window_length_q;
	logic [LW-1:0]  len_q [2 ** SW];
	logic [IW-1:0]  j_q;
	logic [IW-1:0]  q_q;
	logic [WW-1:0]  i_q;
	logic [SW-1:0]  s_q;
	logic [IW-1:0]  pos_q [1:3];
	logic           out_valid_q;
	fscws_pkg::out_item_t out_q;

	logic           accepted;
	logic           append_we;
	logic [LW-1:0]  wlen;
	logic [CW-1:0]  wl_ext;
	logic [CW-1:0]  l0_ext;
	logic [CW-1:0]  ls_ext;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	logic [fscws_pkg::CHAR_W-1:0] rdata_a;
	logic [fscws_pkg::CHAR_W-1:0] rdata_b;
	logic           out_busy;

	// Input transfer and the append write.
	always_comb begin
		accepted  = item_valid && ctrl.accept;
		wlen      = len_q[item.which_string];
		append_we = accepted && (item.kind == fscws_pkg::KIND_APPEND) && (wlen < FULL_LEN);
		waddr     = {item.which_string, wlen[IW-1:0]};
	end

	// Window bounds in a common width.
	always_comb begin
		wl_ext = CW'(window_length_q);
		l0_ext = CW'(len_q[0]);
		ls_ext = CW'(len_q[s_q]);
	end

	// Read addresses: string zero at j+i, string s at q+i.
	always_comb begin
		raddr_a = {SW'(0), j_q + IW'(i_q)};
		raddr_b = {s_q, q_q + IW'(i_q)};
	end

	fscws_ram #(
		.WIDTH(fscws_pkg::CHAR_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.we     (append_we),
		.waddr  (waddr),
		.wdata  (item.char_value),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// Flags for the sequencer.
	always_comb begin
		out_busy          = out_valid_q && !result_ready;
		status.search_acc = accepted && (item.kind == fscws_pkg::KIND_SEARCH);
		status.no_window  = (window_length_q == '0) || (l0_ext < wl_ext);
		status.short_str  = ls_ext < wl_ext;
		status.mismatch   = rdata_a != rdata_b;
		status.i_last     = i_q == (window_length_q - WW'(1));
		status.s_last     = s_q == SW'(3);
		status.q_zero     = q_q == '0;
		status.j_zero     = j_q == '0;
		status.out_busy   = out_busy;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WW'(1);
		end else if (cfg_write_en) begin
			window_length_q <= cfg_write_data;
		end
	end

	// String length counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2 ** SW; k++) begin
				len_q[k] <= '0;
			end
		end else if (accepted && (item.kind == fscws_pkg::KIND_CLEAR)) begin
			for (int k = 0; k < 2 ** SW; k++) begin
				len_q[k] <= '0;
			end
		end else if (append_we) begin
			len_q[item.which_string] <= wlen + LW'(1);
		end
	end

	// Scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			q_q <= '0;
			i_q <= '0;
			s_q <= '0;
		end else begin
			if (ctrl.ld_j) begin
				j_q <= IW'(l0_ext - wl_ext);
			end else if (ctrl.dec_j) begin
				j_q <= j_q - IW'(1);
			end
			if (ctrl.ld_q) begin
				q_q <= IW'(ls_ext - wl_ext);
			end else if (ctrl.dec_q) begin
				q_q <= q_q - IW'(1);
			end
			if (ctrl.clr_i) begin
				i_q <= '0;
			end else if (ctrl.inc_i) begin
				i_q <= i_q + WW'(1);
			end
			if (ctrl.ld_s1) begin
				s_q <= SW'(1);
			end else if (ctrl.inc_s) begin
				s_q <= s_q + SW'(1);
			end
		end
	end

	// Matched starts in strings one to three.
	always_ff @(posedge clk) begin
		if (ctrl.st_pos) begin
			pos_q[s_q] <= q_q;
		end
	end

	// Result register; a finished search waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.emit_hit || ctrl.emit_miss) && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_hit && !out_busy) begin
			out_q.found      <= 1'b1;
			out_q.pos_first  <= PW'(j_q);
			out_q.pos_second <= PW'(pos_q[1]);
			out_q.pos_third  <= PW'(pos_q[2]);
			out_q.pos_fourth <= PW'(pos_q[3]);
		end else if (ctrl.emit_miss && !out_busy) begin
			out_q <= '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== src/four_string_common_window_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-string common window search
// Top level: microcode sequencer driving the string datapath.
// ----------------------------------------------------------------------------
// An append or clear item is taken in the idle step, and the block is ready for the
// next item in the following cycle. A search item holds the input for its whole
// scan, which opens with the INIT and SINIT setup steps. Each compared byte then
// passes through READ, which presents the addresses, CMP, which compares the
// registered reads from the dual-read string memory, and CHKI, which steps to the
// next byte, or NEXTQ, which rejects the start. String changes pass through WDONE
// and SINIT, first-string start changes through NEXTJ and SINIT, and the result
// register is loaded in HIT or MISS. The worst case grows with the product of the
// string lengths and the window length. A finished result waits in the output
// register while later items are taken; a second search that finishes before it
// is drained holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module four_string_common_window_search #(
	parameter int MAX_LEN = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  fscws_pkg::in_item_t          item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output fscws_pkg::out_item_t         result,
	input  logic                         cfg_write_en,
	input  logic [fscws_pkg::WIN_W-1:0]  cfg_write_data
);

	fscws_pkg::ctrl_t   ctrl;
	fscws_pkg::status_t status;

	fscws_useq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl)
	);

	fscws_datapath #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.status        (status),
		.item_valid    (item_valid),
		.item          (item),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.result        (result),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	// The input is open only in the idle step of the program.
	assign item_ready = ctrl.accept;

endmodule

// ===== src/fscws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the window search over time.
// ----------------------------------------------------------------------------
module fscws_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input fscws_pkg::in_item_t          item,
	input logic                         result_valid,
	input logic                         result_ready,
	input fscws_pkg::out_item_t         result
);

	// A result that is not taken holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A miss reports all positions as zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |->
		result.pos_first == '0 && result.pos_second == '0 &&
		result.pos_third == '0 && result.pos_fourth == '0)
		else $error("miss result with nonzero position");

	// A search transfer closes the input for at least the next cycle.
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.kind == fscws_pkg::KIND_SEARCH |=> !item_ready)
		else $error("input open right after a search transfer");

	// Appends and clears never close the input.
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.kind != fscws_pkg::KIND_SEARCH |=> item_ready)
		else $error("input closed after an append or clear transfer");

	// A new result only appears at the end of a search scan.
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without a search scan");

endmodule

bind four_string_common_window_search fscws_checker u_fscws_checker (.*);
